// ----- design/lfsrsc_pkg.sv -----
// ----------------------------------------------------------------------------
// lfsrsc_pkg: shared types and constants for the lfsr seed cover counter
// Sequencer states, controller command and datapath status groups, field widths.
// ----------------------------------------------------------------------------
package lfsrsc_pkg;

	// fixed field widths
	localparam int TAP_W            = 16;
	localparam int COUNT_W          = 17;
	localparam int MAX_TAP_BITS_DEF = 16;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CLEAR,
		ST_SCAN,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_DONE
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;        // capture the tap mask
		logic setup;       // derive masks, init counters
		logic clr;         // clear one map entry
		logic scan_step;   // stream one scan read
		logic scan_stop;   // drop the scan read in flight
		logic start_walk;  // start a walk at the found state
		logic walk_rd;     // read the visited bit of the walk state
		logic walk_mark;   // mark the walk state and step the register
		logic emit;        // load the result register
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic tap_zero;     // empty mask
		logic ptr_last;     // clear pointer on the last state
		logic all_covered;  // every state visited
		logic found;        // scan hit an unvisited state
		logic visited;      // walk state already marked
		logic out_free;     // result register can take a new value
	} status_t;

endpackage

// ----- design/lfsr_seed_cover_counter_top.sv -----
// ----------------------------------------------------------------------------
// lfsr_seed_cover_counter_top: seed cover counter for a Fibonacci shift register
// Counts the walks, zero state included, that together visit every state.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, tap_mask) takes one tap mask per
//   transfer; the register width L is the bit length of the mask, limited to
//   MAX_TAP_BITS. Output channel (out_valid, out_stall, seed_count) returns
//   one count per input transfer, in order.
//   One item at a time. An item runs through setup, a clear of the visited
//   map, then a scan for unvisited states, with a walk from each one found:
//   its start, then a read and a check of each state until one already
//   visited is met, and a mark of each state the walk reaches. A zero mask
//   skips the clear and the scan. The single read and write port of the
//   visited map sets the pace of this work.
//   in_stall is high while an item is being worked on.
//   The result sits in an output register; a stalled receiver holds it there
//   while the next item is already taken and worked on, and only the final
//   hand-off of that next item waits for the register to drain.
//   Reset (arst_n low) returns the sequencer to idle and drops any pending
//   result; the map needs no clearing pass since every item clears it.
// ----------------------------------------------------------------------------
module lfsr_seed_cover_counter_top #(
	parameter int MAX_TAP_BITS = lfsrsc_pkg::MAX_TAP_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [lfsrsc_pkg::TAP_W-1:0]   tap_mask,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [lfsrsc_pkg::COUNT_W-1:0] seed_count
);

	lfsrsc_pkg::cmd_t    cmd;
	lfsrsc_pkg::status_t sts;

	// sequencer
	lfsrsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	lfsrsc_dp #(
		.MAX_TAP_BITS (MAX_TAP_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.tap_mask   (tap_mask),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.seed_count (seed_count)
	);

	// the zero state always counts, so a result is never zero
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (seed_count != '0))
		else $error("zero seed count on output");

endmodule

// ----- design/lfsrsc_ram.sv -----
// ----------------------------------------------------------------------------
// lfsrsc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lfsrsc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- design/lfsrsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lfsrsc_ctrl: sequencer for the seed cover counter
// Steps through load, map clear, scan for unvisited states, walks and result.
// ----------------------------------------------------------------------------
module lfsrsc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  lfsrsc_pkg::status_t sts,
	output lfsrsc_pkg::cmd_t    cmd
);

	lfsrsc_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfsrsc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			lfsrsc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = lfsrsc_pkg::ST_LOAD;
				end
			end
			lfsrsc_pkg::ST_LOAD: begin
				cmd.setup = 1'b1;
				state_d   = sts.tap_zero ? lfsrsc_pkg::ST_DONE : lfsrsc_pkg::ST_CLEAR;
			end
			lfsrsc_pkg::ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.ptr_last) begin
					state_d = lfsrsc_pkg::ST_SCAN;
				end
			end
			lfsrsc_pkg::ST_SCAN: begin
				if (sts.all_covered) begin
					cmd.scan_stop = 1'b1;
					state_d       = lfsrsc_pkg::ST_DONE;
				end else if (sts.found) begin
					cmd.start_walk = 1'b1;
					state_d        = lfsrsc_pkg::ST_WALK_RD;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			lfsrsc_pkg::ST_WALK_RD: begin
				cmd.walk_rd = 1'b1;
				state_d     = lfsrsc_pkg::ST_WALK_CHK;
			end
			lfsrsc_pkg::ST_WALK_CHK: begin
				if (sts.visited) begin
					state_d = lfsrsc_pkg::ST_SCAN;
				end else begin
					cmd.walk_mark = 1'b1;
					state_d       = lfsrsc_pkg::ST_WALK_RD;
				end
			end
			lfsrsc_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = lfsrsc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lfsrsc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- design/lfsrsc_dp.sv -----
// ----------------------------------------------------------------------------
// lfsrsc_dp: datapath for the seed cover counter
// Visited map, scan pointer, walk register, counters and result register.
// ----------------------------------------------------------------------------
module lfsrsc_dp #(
	parameter int MAX_TAP_BITS = lfsrsc_pkg::MAX_TAP_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lfsrsc_pkg::cmd_t                  cmd,
	output lfsrsc_pkg::status_t               sts,
	input  logic [lfsrsc_pkg::TAP_W-1:0]      tap_mask,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [lfsrsc_pkg::COUNT_W-1:0]    seed_count
);

	// usable register width and map depth
	localparam int TB =
		(MAX_TAP_BITS < lfsrsc_pkg::TAP_W) ? MAX_TAP_BITS : lfsrsc_pkg::TAP_W;
	localparam int DEPTH = 1 << TB;

	logic [TB-1:0] tap_q;
	logic [TB-1:0] last_q;
	logic [TB-1:0] low_mask_q;
	logic [TB-1:0] ptr_q;
	logic [TB-1:0] chk_addr_q;
	logic          chk_vld_q;
	logic [TB-1:0] s_q;
	logic [TB:0]   covered_q;
	logic [TB:0]   seeds_q;
	logic          out_vld_q;
	logic [lfsrsc_pkg::COUNT_W-1:0] seed_count_q;

	logic [TB-1:0] smear;
	logic          run;
	logic [TB-1:0] s_next;
	logic          rd_en;
	logic [TB-1:0] rd_addr;
	logic          wr_en;
	logic [TB-1:0] wr_addr;
	logic          wr_data;
	logic          rd_data;

	// fill every bit at and below the top set tap bit
	always_comb begin
		run   = 1'b0;
		smear = '0;
		for (int i = TB - 1; i >= 0; i--) begin
			run      = run | tap_q[i];
			smear[i] = run;
		end
	end

	// shift register step
	assign s_next = ((s_q & low_mask_q) << 1) | TB'(^(tap_q & s_q));

	// map port selection
	assign rd_en   = cmd.scan_step | cmd.walk_rd;
	assign rd_addr = cmd.scan_step ? ptr_q : s_q;
	assign wr_en   = cmd.clr | cmd.walk_mark;
	assign wr_addr = cmd.clr ? ptr_q : s_q;
	assign wr_data = cmd.clr ? (ptr_q == '0) : 1'b1;

	lfsrsc_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// status back to the sequencer
	always_comb begin
		sts             = '0;
		sts.tap_zero    = (tap_q == '0);
		sts.ptr_last    = (ptr_q == last_q);
		sts.all_covered = (covered_q == ({1'b0, last_q} + (TB + 1)'(1)));
		sts.found       = chk_vld_q & ~rd_data;
		sts.visited     = rd_data;
		sts.out_free    = ~out_vld_q | ~out_stall;
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tap_q <= tap_mask[TB-1:0];
		end
		if (cmd.setup) begin
			last_q     <= smear;
			low_mask_q <= smear >> 1;
			ptr_q      <= '0;
			covered_q  <= (TB + 1)'(1);
			seeds_q    <= (TB + 1)'(1);
		end
		if (cmd.clr) begin
			ptr_q <= sts.ptr_last ? TB'(1) : ptr_q + TB'(1);
		end
		if (cmd.scan_step) begin
			ptr_q      <= ptr_q + TB'(1);
			chk_addr_q <= ptr_q;
		end
		if (cmd.start_walk) begin
			s_q     <= chk_addr_q;
			ptr_q   <= chk_addr_q + TB'(1);
			seeds_q <= seeds_q + (TB + 1)'(1);
		end
		if (cmd.walk_mark) begin
			s_q       <= s_next;
			covered_q <= covered_q + (TB + 1)'(1);
		end
		if (cmd.emit) begin
			seed_count_q <= lfsrsc_pkg::COUNT_W'(seeds_q);
		end
	end

	// scan read in flight and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.scan_step) begin
				chk_vld_q <= 1'b1;
			end else if (cmd.setup || cmd.scan_stop || cmd.start_walk) begin
				chk_vld_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_vld_q;
	assign seed_count = seed_count_q;

	// a walk never marks more states than the register has
	a_cover_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_mark |-> (covered_q <= {1'b0, last_q}))
		else $error("walk marks beyond the state count");

	// state zero is the first seed and is never walked into
	a_no_zero_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_mark |-> (s_q != '0))
		else $error("walk reached state zero");

	// a walk starts only while states are left uncovered
	a_walk_needed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_walk |-> !sts.all_covered)
		else $error("walk started with every state covered");

endmodule

// ----- bench/seed_count_checker.sv -----
// ----------------------------------------------------------------------------
// seed_count_checker: result checker for the lfsr seed cover counter
// Watches both channels. It works out the seed count for every tap mask
// taken in and compares each returned count, in order, with that figure.
// ----------------------------------------------------------------------------
module seed_count_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [lfsrsc_pkg::TAP_W-1:0]   tap_mask,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [lfsrsc_pkg::COUNT_W-1:0] seed_count,
	output int                             fail_count,
	output int                             pending,
	output int                             results_done
);

	typedef struct {
		logic [lfsrsc_pkg::TAP_W-1:0]   taps;
		logic [lfsrsc_pkg::COUNT_W-1:0] seeds;
	} cover_expect_t;

	cover_expect_t expected_counts [$];

	// one visited bit per register state
	bit seen_map [0:(1 << lfsrsc_pkg::TAP_W) - 1];

	// number of walks, the zero state's included, that cover all 2^L states
	function logic [lfsrsc_pkg::COUNT_W-1:0] count_cover_seeds(
		input logic [lfsrsc_pkg::TAP_W-1:0] taps);
		int unsigned width, states, low_bits, covered, scan, seeds, s;
		width = 0;
		for (int i = 0; i < lfsrsc_pkg::TAP_W; i++)
			if (taps[i])
				width = i + 1;
		if (width == 0)
			return lfsrsc_pkg::COUNT_W'(1);
		states   = 1 << width;
		low_bits = (1 << (width - 1)) - 1;
		for (int i = 0; i < states; i++)
			seen_map[i] = 1'b0;
		seen_map[0] = 1'b1;
		covered = 1;
		seeds   = 1;
		scan    = 1;
		while (covered < states) begin
			while (scan < states && seen_map[scan])
				scan++;
			// a new walk from the lowest state not yet reached
			seeds++;
			s = scan;
			while (!seen_map[s]) begin
				seen_map[s] = 1'b1;
				covered++;
				s = ((s & low_bits) << 1) | (^(taps & s[lfsrsc_pkg::TAP_W-1:0]));
			end
		end
		return seeds[lfsrsc_pkg::COUNT_W-1:0];
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	// results are matched before new masks are queued
	always @(posedge clk) begin
		cover_expect_t want;
		if (!arst_n) begin
			fail_count   = 0;
			pending      <= 0;
			results_done <= 0;
			expected_counts.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_counts.size() == 0) begin
					report_mismatch($sformatf("seed_count %0d with no mask waiting", seed_count));
				end else begin
					want = expected_counts.pop_front();
					if (seed_count !== want.seeds)
						report_mismatch($sformatf("tap_mask %h: seed_count %0d, expected %0d",
							want.taps, seed_count, want.seeds));
				end
				results_done <= results_done + 1;
			end
			if (in_valid && !in_stall) begin
				want.taps  = tap_mask;
				want.seeds = count_cover_seeds(tap_mask);
				expected_counts.push_back(want);
			end
			pending <= expected_counts.size();
		end
	end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: top level bench for lfsr_seed_cover_counter_top
// Sends corner tap masks, then random ones of mostly small width, with random
// gaps on the sender and random stalls on the receiver, one long hold-off
// among them. A checker beside the block predicts and compares every count.
// ----------------------------------------------------------------------------
module testbench;

	// longest stretch with no transfer, set above the run time of a full 16-bit item
	localparam int WATCHDOG_LIMIT = 1000000;
	localparam int HOLD_CYCLES    = 8000;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic [lfsrsc_pkg::TAP_W-1:0]   tap_mask;
	logic                           out_valid;
	logic                           out_stall;
	logic [lfsrsc_pkg::COUNT_W-1:0] seed_count;
	int                             fail_count;
	int                             pending;
	int                             results_done;
	int                             quiet_cycles = 0;

	lfsr_seed_cover_counter_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.tap_mask   (tap_mask),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.seed_count (seed_count)
	);

	seed_count_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.tap_mask     (tap_mask),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.seed_count   (seed_count),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_done (results_done)
	);

	always #4 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(30, 150);
	endfunction

	// offer one mask until the transfer happens, then maybe go idle
	task automatic send_mask(input logic [lfsrsc_pkg::TAP_W-1:0] m);
		int gap;
		in_valid <= 1'b1;
		tap_mask <= m;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stimulus and verdict
	initial begin
		int                           width;
		int                           pick;
		logic [lfsrsc_pkg::TAP_W-1:0] m;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		tap_mask  = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners: empty mask, tiny widths, full width, single and dense taps
		send_mask(16'h0000);
		send_mask(16'h0001);
		send_mask(16'h0002);
		send_mask(16'h0003);
		send_mask(16'h0005);
		send_mask(16'h0006);
		send_mask(16'h0009);
		send_mask(16'h000c);
		send_mask(16'h0013);
		send_mask(16'h001d);
		send_mask(16'h0080);
		send_mask(16'h00b8);
		send_mask(16'h00ff);
		send_mask(16'h0100);
		send_mask(16'h0555);
		send_mask(16'h0aaa);
		send_mask(16'h8000);
		send_mask(16'hffff);
		send_mask(16'h0000);

		// random masks, most of small width so each item stays short
		repeat (81) begin
			pick = $urandom_range(0, 99);
			if (pick < 5)
				width = 0;
			else if (pick < 80)
				width = $urandom_range(1, 8);
			else if (pick < 95)
				width = $urandom_range(9, 11);
			else
				width = $urandom_range(12, 13);
			if (width == 0)
				m = '0;
			else
				m = (16'd1 << (width - 1)) |
					(16'($urandom) & ((16'd1 << (width - 1)) - 16'd1));
			send_mask(m);
		end
		in_valid <= 1'b0;
		@(posedge clk);

		// drain, then let the block settle
		while (pending != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// receiver: random stalls, one long hold-off once results are flowing
	initial begin
		bit held;
		int free_len, busy_len;
		held      = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && results_done >= 30) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				held = 1'b1;
			end
			free_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
				: $urandom_range(1, 12);
			out_stall <= 1'b0;
			repeat (free_len) @(posedge clk);
			busy_len = pick_gap();
			if (busy_len > 0) begin
				out_stall <= 1'b1;
				repeat (busy_len) @(posedge clk);
			end
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

// ----- lfsr_seed_cover_counter_top.f -----
design/lfsrsc_pkg.sv
design/lfsrsc_ram.sv
design/lfsrsc_ctrl.sv
design/lfsrsc_dp.sv
design/lfsr_seed_cover_counter_top.sv
bench/seed_count_checker.sv
bench/testbench.sv
